// File: design/bwpt_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and sign-extension helpers for the body-to-world
// point transform. No dependencies.
package bwpt_pkg;

  // Default coordinate width (signed fixed point, binary point passes through)
  localparam int COORD_WIDTH_DEF = 32;

  // Quaternion components: signed Q2.30
  localparam int QUAT_W    = 32;
  localparam int QUAT_FRAC = 30;

  // Floor-rounded quaternion product f(a,b) = floor(a*b / 2^30)
  localparam int F_W = 2 * QUAT_W - QUAT_FRAC;

  // Rotation matrix entry width (Q30, magnitude up to about 2^34)
  localparam int R_W = F_W + 2;

  // Shared multiplier: R_W x MUL_B_W signed
  localparam int MUL_B_W = QUAT_W + 1;
  localparam int PROD_W  = R_W + MUL_B_W;

  // Coordinates are split into a low unsigned chunk and a signed high chunk
  localparam int SPLIT_W = 24;

  localparam logic signed [R_W-1:0] R_ONE = R_W'(1) <<< QUAT_FRAC;

  // Sign-extend a quaternion component to the multiplier A operand width
  function automatic logic signed [R_W-1:0] sx_qa(input logic signed [QUAT_W-1:0] v);
    return {{(R_W-QUAT_W){v[QUAT_W-1]}}, v};
  endfunction

  // Sign-extend a quaternion component to the multiplier B operand width
  function automatic logic signed [MUL_B_W-1:0] sx_qb(input logic signed [QUAT_W-1:0] v);
    return {{(MUL_B_W-QUAT_W){v[QUAT_W-1]}}, v};
  endfunction

  // Sign-extend a floor-rounded product to the matrix entry width
  function automatic logic signed [R_W-1:0] sx_f(input logic signed [F_W-1:0] v);
    return {{(R_W-F_W){v[F_W-1]}}, v};
  endfunction

endpackage

// File: design/body_to_world_point_transform_core.sv
`timescale 1ns / 1ps
// Top level of the body-to-world point transform: sequencer, shared multiplier,
// matrix build, accumulation and saturation. Depends on bwpt_pkg.
//
// Each request carries a body-frame point, the body position and an
// orientation quaternion, and yields one world point world = R(q)*p + pos,
// saturated per coordinate. A request whose meas_x is zero uses the last held
// point instead (used_held = 1); any request with nonzero meas_x replaces the
// held point. The quaternion is not normalized. All arithmetic runs through a
// single signed 36x33 multiplier with a two-stage pipeline: 9 quaternion
// products, a step that forms the matrix, then 18 partial products (each
// coordinate split into a 24-bit low and a signed high chunk). The block is
// not ready for the next request until the result is valid, and a finished
// result is held back while an earlier one still waits on out_ready.
// A new request may be taken while a finished result still waits on
// out_ready.
module body_to_world_point_transform_core #(
  parameter int COORD_WIDTH = bwpt_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH-1:0]         meas_x,
  input  logic signed [COORD_WIDTH-1:0]         meas_y,
  input  logic signed [COORD_WIDTH-1:0]         meas_z,
  input  logic signed [COORD_WIDTH-1:0]         pos_x,
  input  logic signed [COORD_WIDTH-1:0]         pos_y,
  input  logic signed [COORD_WIDTH-1:0]         pos_z,
  input  logic signed [bwpt_pkg::QUAT_W-1:0]    quat_w,
  input  logic signed [bwpt_pkg::QUAT_W-1:0]    quat_x,
  input  logic signed [bwpt_pkg::QUAT_W-1:0]    quat_y,
  input  logic signed [bwpt_pkg::QUAT_W-1:0]    quat_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_WIDTH-1:0]         world_x,
  output logic signed [COORD_WIDTH-1:0]         world_y,
  output logic signed [COORD_WIDTH-1:0]         world_z,
  output logic                                  used_held
);
  import bwpt_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int ACC_W  = CW + 37;
  localparam int PE_W   = CW + SPLIT_W;
  localparam int SUM_W  = CW + 8;
  localparam int CWIDE_W = PROD_W + SPLIT_W;

  // Sequencer steps
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] STEP_QUAT_LAST = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_MATRIX    = STEP_W'(11);
  localparam logic [STEP_W-1:0] STEP_DOT_FIRST = STEP_W'(12);
  localparam logic [STEP_W-1:0] STEP_DOT_LAST  = STEP_W'(29);
  localparam logic [STEP_W-1:0] STEP_FINISH    = STEP_W'(32);

  // Quaternion product slots
  localparam logic [3:0] F_XX = 4'd0;
  localparam logic [3:0] F_YY = 4'd1;
  localparam logic [3:0] F_ZZ = 4'd2;
  localparam logic [3:0] F_XY = 4'd3;
  localparam logic [3:0] F_XZ = 4'd4;
  localparam logic [3:0] F_YZ = 4'd5;
  localparam logic [3:0] F_WX = 4'd6;
  localparam logic [3:0] F_WY = 4'd7;
  localparam logic [3:0] F_WZ = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY
  } state_t;

  typedef struct packed {
    logic       valid;
    logic       dot;
    logic [3:0] fidx;
    logic [1:0] row;
    logic       first;
    logic       hi;
  } tag_t;

  state_t              state;
  logic [STEP_W-1:0]   cnt;

  // Request registers
  logic signed [CW-1:0]     held_pt [3];
  logic signed [CW-1:0]     p_reg   [3];
  logic signed [CW-1:0]     pos_reg [3];
  logic signed [QUAT_W-1:0] q_w, q_x, q_y, q_z;
  logic                     used_reg;

  // Datapath registers
  logic signed [F_W-1:0]     f_val [9];
  logic signed [R_W-1:0]     r_mat [9];
  logic signed [ACC_W-1:0]   acc   [3];
  logic signed [R_W-1:0]     op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [PROD_W-1:0]  prod;
  tag_t                      s1, s2;
  tag_t                      s1_next;
  logic [1:0]                d_row, d_col;
  logic                      d_half;

  logic in_acc;
  logic finish;
  logic issue_quat, issue_dot;

  logic signed [R_W-1:0]     qa_sel;
  logic signed [MUL_B_W-1:0] qb_sel;
  logic signed [PE_W-1:0]    p_ext, p_shift;
  logic signed [MUL_B_W-1:0] chunk_sel;
  logic [3:0]                r_idx;
  logic signed [CWIDE_W-1:0] contrib_wide;
  logic signed [CW-1:0]      world_next [3];

  assign in_ready   = (state == ST_IDLE) && !rst;
  assign in_acc     = in_valid && in_ready;
  assign finish     = (state == ST_BUSY) && (cnt == STEP_FINISH) && (!out_valid || out_ready);
  assign issue_quat = (state == ST_BUSY) && (cnt <= STEP_QUAT_LAST);
  assign issue_dot  = (state == ST_BUSY) && (cnt >= STEP_DOT_FIRST) && (cnt <= STEP_DOT_LAST);

  // Select the quaternion operand pair for this step
  always_comb begin
    qa_sel = sx_qa(q_x);
    qb_sel = sx_qb(q_x);
    case (cnt[3:0])
      F_XX: begin qa_sel = sx_qa(q_x); qb_sel = sx_qb(q_x); end
      F_YY: begin qa_sel = sx_qa(q_y); qb_sel = sx_qb(q_y); end
      F_ZZ: begin qa_sel = sx_qa(q_z); qb_sel = sx_qb(q_z); end
      F_XY: begin qa_sel = sx_qa(q_x); qb_sel = sx_qb(q_y); end
      F_XZ: begin qa_sel = sx_qa(q_x); qb_sel = sx_qb(q_z); end
      F_YZ: begin qa_sel = sx_qa(q_y); qb_sel = sx_qb(q_z); end
      F_WX: begin qa_sel = sx_qa(q_w); qb_sel = sx_qb(q_x); end
      F_WY: begin qa_sel = sx_qa(q_w); qb_sel = sx_qb(q_y); end
      F_WZ: begin qa_sel = sx_qa(q_w); qb_sel = sx_qb(q_z); end
      default: begin qa_sel = sx_qa(q_x); qb_sel = sx_qb(q_x); end
    endcase
  end

  // Split the current coordinate into low unsigned and high signed chunks
  always_comb begin
    p_ext   = {{SPLIT_W{p_reg[d_col][CW-1]}}, p_reg[d_col]};
    p_shift = p_ext >>> SPLIT_W;
    if (d_half) begin
      chunk_sel = p_shift[MUL_B_W-1:0];
    end else begin
      chunk_sel = {{(MUL_B_W-SPLIT_W){1'b0}}, p_ext[SPLIT_W-1:0]};
    end
    r_idx = 4'(d_row) * 4'd3 + 4'(d_col);
  end

  // Form the tag for the operand pair issued this cycle
  always_comb begin
    s1_next = '0;
    if (issue_quat) begin
      s1_next.valid = 1'b1;
      s1_next.fidx  = cnt[3:0];
    end else if (issue_dot) begin
      s1_next.valid = 1'b1;
      s1_next.dot   = 1'b1;
      s1_next.row   = d_row;
      s1_next.first = (d_col == 2'd0) && !d_half;
      s1_next.hi    = d_half;
    end
  end

  // Align a partial product for accumulation
  always_comb begin
    if (s2.hi) begin
      contrib_wide = {prod, {SPLIT_W{1'b0}}};
    end else begin
      contrib_wide = {{SPLIT_W{prod[PROD_W-1]}}, prod};
    end
  end

  // Drop the fraction, add the position and saturate each coordinate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [SUM_W-1:0] sum;
      logic signed [CW+6:0]    row_val;
      row_val = acc[i][ACC_W-1:QUAT_FRAC];
      sum = {row_val[CW+6], row_val} + {{8{pos_reg[i][CW-1]}}, pos_reg[i]};
      if (!sum[SUM_W-1] && (|sum[SUM_W-2:CW-1])) begin
        world_next[i] = {1'b0, {(CW-1){1'b1}}};
      end else if (sum[SUM_W-1] && !(&sum[SUM_W-2:CW-1])) begin
        world_next[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        world_next[i] = sum[CW-1:0];
      end
    end
  end

  // Hold state, step counter, held point and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        held_pt[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && !finish) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_BUSY;
            cnt   <= '0;
            if (meas_x != '0) begin
              held_pt[0] <= meas_x;
              held_pt[1] <= meas_y;
              held_pt[2] <= meas_z;
            end
          end
        end
        ST_BUSY: begin
          if (cnt != STEP_FINISH) begin
            cnt <= cnt + STEP_W'(1);
          end else if (finish) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
            world_x   <= world_next[0];
            world_y   <= world_next[1];
            world_z   <= world_next[2];
            used_held <= used_reg;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (meas_x == '0) begin
        p_reg[0] <= held_pt[0];
        p_reg[1] <= held_pt[1];
        p_reg[2] <= held_pt[2];
        used_reg <= 1'b1;
      end else begin
        p_reg[0] <= meas_x;
        p_reg[1] <= meas_y;
        p_reg[2] <= meas_z;
        used_reg <= 1'b0;
      end
      pos_reg[0] <= pos_x;
      pos_reg[1] <= pos_y;
      pos_reg[2] <= pos_z;
      q_w <= quat_w;
      q_x <= quat_x;
      q_y <= quat_y;
      q_z <= quat_z;
    end
  end

  // Issue control: tag pipeline and dot-product step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      s1     <= '0;
      s2     <= '0;
      d_row  <= '0;
      d_col  <= '0;
      d_half <= 1'b0;
    end else begin
      s2 <= s1;
      s1 <= s1_next;
      if (in_acc) begin
        d_row  <= '0;
        d_col  <= '0;
        d_half <= 1'b0;
      end else if (issue_dot) begin
        // Advance half, then column, then row
        d_half <= !d_half;
        if (d_half) begin
          if (d_col == 2'd2) begin
            d_col <= '0;
            d_row <= d_row + 2'd1;
          end else begin
            d_col <= d_col + 2'd1;
          end
        end
      end
    end
  end

  // Load operands, multiply, write back products and accumulate
  always_ff @(posedge clk) begin
    if (issue_quat) begin
      op_a <= qa_sel;
      op_b <= qb_sel;
    end else if (issue_dot) begin
      op_a <= r_mat[r_idx];
      op_b <= chunk_sel;
    end
    prod <= op_a * op_b;
    if (s2.valid && !s2.dot) begin
      f_val[s2.fidx] <= prod[QUAT_FRAC +: F_W];
    end
    if (s2.valid && s2.dot) begin
      if (s2.first) begin
        acc[s2.row] <= contrib_wide[ACC_W-1:0];
      end else begin
        acc[s2.row] <= acc[s2.row] + contrib_wide[ACC_W-1:0];
      end
    end
    // Build the rotation matrix from the floor-rounded products
    if ((state == ST_BUSY) && (cnt == STEP_MATRIX)) begin
      r_mat[0] <= R_ONE - ((sx_f(f_val[F_YY]) + sx_f(f_val[F_ZZ])) <<< 1);
      r_mat[1] <= (sx_f(f_val[F_XY]) - sx_f(f_val[F_WZ])) <<< 1;
      r_mat[2] <= (sx_f(f_val[F_XZ]) + sx_f(f_val[F_WY])) <<< 1;
      r_mat[3] <= (sx_f(f_val[F_XY]) + sx_f(f_val[F_WZ])) <<< 1;
      r_mat[4] <= R_ONE - ((sx_f(f_val[F_XX]) + sx_f(f_val[F_ZZ])) <<< 1);
      r_mat[5] <= (sx_f(f_val[F_YZ]) - sx_f(f_val[F_WX])) <<< 1;
      r_mat[6] <= (sx_f(f_val[F_XZ]) - sx_f(f_val[F_WY])) <<< 1;
      r_mat[7] <= (sx_f(f_val[F_YZ]) + sx_f(f_val[F_WX])) <<< 1;
      r_mat[8] <= R_ONE - ((sx_f(f_val[F_XX]) + sx_f(f_val[F_YY])) <<< 1);
    end
  end

  // A taken request blocks the input until its result is formed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a request was taken");

  // A nonzero measurement becomes the held point
  a_held_update: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (meas_x != '0) |=> held_pt[0] == $past(meas_x))
    else $error("held point not updated from a nonzero measurement");

  // Partial products reach the accumulator only after the matrix is built
  a_dot_after_matrix: assert property (@(posedge clk) disable iff (rst)
    s2.valid && s2.dot |-> (state == ST_BUSY) && (cnt >= STEP_DOT_FIRST + STEP_W'(2)))
    else $error("dot-product writeback outside its window");

  // Quaternion products are written back before the matrix step
  a_quat_before_matrix: assert property (@(posedge clk) disable iff (rst)
    s2.valid && !s2.dot |-> (state == ST_BUSY) && (cnt < STEP_MATRIX))
    else $error("quaternion product writeback after the matrix step");

endmodule
